// ----- rtl/core/bblc_pkg.sv -----
package bblc_pkg;

  localparam int DEF_TABLE_SLOTS = 64;
  localparam int DEF_KEY_WIDTH = 64;
  localparam logic [31:0] MAX_BYTES_RESET = 32'd67108864;
  localparam int IN_TDATA_W = 136;
  localparam int OUT_TDATA_W = 168;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_LOOKUP   = 3'd1,
    REQ_CONTAINS = 3'd2,
    REQ_REMOVE   = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_RANK,
    S_DISPATCH,
    S_TOUCH,
    S_EVCHK,
    S_EVSEL,
    S_EVRD,
    S_EVDROP,
    S_WRITE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_req;
    logic srch_start;
    logic srch_cmp;
    logic rd_en;
    logic rd_oldest;
    logic calc_rank;
    logic sel_oldest;
    logic drop;
    logic drop_evict;
    logic touch;
    logic count_hit;
    logic count_miss;
    logic write_new;
    logic clear_all;
    logic set_ok;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic ins_legal;
    logic found;
    logic kind_match;
    logic over_budget;
    logic full;
    logic nonempty;
  } sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/core/bblc_ctrl.sv -----
module bblc_ctrl
  import bblc_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  sts_t                           sts,
  output cmd_t                           cmd,
  output logic [$clog2(TABLE_SLOTS)-1:0] rd_addr
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;
  assign rd_addr = cnt[IW-1:0];

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    s_tready = 1'b0;
    out_valid_next = out_valid && !m_tready;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_next = '0;
        case (sts.req)
          REQ_INSERT: begin
            if (sts.ins_legal) begin
              cmd.srch_start = 1'b1;
              state_next = S_SEARCH;
            end else begin
              state_next = S_FINISH;
            end
          end
          REQ_LOOKUP, REQ_CONTAINS, REQ_REMOVE: begin
            cmd.srch_start = 1'b1;
            state_next = S_SEARCH;
          end
          REQ_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next = S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_SEARCH: begin
        cmd.rd_en = (cnt < CW'(TABLE_SLOTS));
        cmd.srch_cmp = (cnt != '0);
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(TABLE_SLOTS)) begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        cmd.calc_rank = 1'b1;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        case (sts.req)
          REQ_LOOKUP: begin
            if (sts.found && sts.kind_match) begin
              state_next = S_TOUCH;
            end else begin
              cmd.count_miss = 1'b1;
            end
          end
          REQ_CONTAINS: cmd.set_ok = sts.found;
          REQ_REMOVE: begin
            cmd.drop = sts.found;
            cmd.set_ok = sts.found;
          end
          REQ_INSERT: begin
            cmd.drop = sts.found;
            state_next = S_EVCHK;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_TOUCH: begin
        cmd.touch = 1'b1;
        cmd.count_hit = 1'b1;
        cmd.set_ok = 1'b1;
        state_next = S_FINISH;
      end
      S_EVCHK: begin
        if (sts.over_budget || sts.full) begin
          state_next = S_EVSEL;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_EVSEL: begin
        cmd.sel_oldest = 1'b1;
        state_next = S_EVRD;
      end
      S_EVRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_oldest = 1'b1;
        state_next = S_EVDROP;
      end
      S_EVDROP: begin
        cmd.drop = 1'b1;
        cmd.drop_evict = 1'b1;
        state_next = S_EVCHK;
      end
      S_WRITE: begin
        cmd.write_new = 1'b1;
        cmd.set_ok = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/bblc_dpath.sv -----
module bblc_dpath
  import bblc_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [IN_TDATA_W-1:0]          s_tdata,
  output logic [OUT_TDATA_W-1:0]         m_tdata,
  input  logic                           cfg_wen,
  input  logic [31:0]                    cfg_wdata,
  input  cmd_t                           cmd,
  input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
  output sts_t                           sts
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int EW = $clog2(TABLE_SLOTS + 1);
  localparam int MW = KEY_WIDTH + 65;

  logic [31:0] max_bytes;
  req_e req_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic kind_q;
  logic [31:0] size_q;
  logic [31:0] handle_q;
  logic present_q;

  logic [TABLE_SLOTS-1:0] valid;
  logic [IW-1:0] rank [TABLE_SLOTS];
  logic [MW-1:0] mem [TABLE_SLOTS];
  logic [MW-1:0] mem_q;
  logic [IW-1:0] rd_addr_q;
  logic [IW-1:0] rd_mux;

  logic [31:0] bytes_in_use;
  logic [EW-1:0] entries;
  logic [31:0] hits;
  logic [31:0] misses;
  logic [31:0] evictions;

  logic found;
  logic have_free;
  logic [IW-1:0] sel_idx;
  logic [IW-1:0] free_idx;
  logic [TABLE_SLOTS-1:0] sel_oh;
  logic [IW-1:0] rsel;
  logic found_kind;
  logic [31:0] found_size;
  logic [31:0] found_handle;
  logic ok_q;
  logic [31:0] res_q;

  logic [31:0] lim;
  logic [IW-1:0] rank_or;
  logic [IW-1:0] old_idx;
  logic [IW-1:0] last_rank;
  logic [31:0] dsize;
  logic [KEY_WIDTH-1:0] mem_key;

  assign lim = (max_bytes == '0) ? 32'd1 : max_bytes;
  assign last_rank = IW'(entries - 1'b1);
  assign mem_key = mem_q[MW-1 -: KEY_WIDTH];
  assign dsize = cmd.drop_evict ? mem_q[63:32] : found_size;
  assign rd_mux = cmd.rd_oldest ? sel_idx : rd_addr;

  assign sts.req = req_q;
  assign sts.ins_legal = present_q && (size_q <= lim);
  assign sts.found = found;
  assign sts.kind_match = (found_kind == kind_q);
  assign sts.nonempty = (entries != '0);
  assign sts.over_budget = (entries != '0) &&
                           ({1'b0, bytes_in_use} + {1'b0, size_q} > {1'b0, lim});
  assign sts.full = (entries >= EW'(TABLE_SLOTS));

  always_comb begin
    rank_or = '0;
    old_idx = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (sel_oh[i]) rank_or = rank_or | rank[i];
      if (valid[i] && rank[i] == last_rank) old_idx = old_idx | IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_wen) begin
      max_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_e'(s_tdata[2:0]);
      key_q <= s_tdata[3 +: KEY_WIDTH];
      kind_q <= s_tdata[67];
      size_q <= (s_tdata[99:68] == '0) ? 32'd1 : s_tdata[99:68];
      handle_q <= s_tdata[131:100];
      present_q <= s_tdata[132];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_new) begin
      mem[free_idx] <= {key_q, kind_q, size_q, handle_q};
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_mux];
    end
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (cmd.drop && valid[i] && rank[i] > rsel) begin
        rank[i] <= rank[i] - 1'b1;
      end
      if (cmd.touch && valid[i] && rank[i] < rsel) begin
        rank[i] <= rank[i] + 1'b1;
      end
      if (cmd.write_new && valid[i]) begin
        rank[i] <= rank[i] + 1'b1;
      end
    end
    if (cmd.touch) rank[sel_idx] <= '0;
    if (cmd.write_new) rank[free_idx] <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      bytes_in_use <= '0;
      entries <= '0;
      hits <= '0;
      misses <= '0;
      evictions <= '0;
    end else begin
      if (cmd.clear_all) begin
        valid <= '0;
        bytes_in_use <= '0;
        entries <= '0;
      end
      if (cmd.drop) begin
        valid[sel_idx] <= 1'b0;
        bytes_in_use <= bytes_in_use - dsize;
        entries <= entries - 1'b1;
      end
      if (cmd.write_new) begin
        valid[free_idx] <= 1'b1;
        bytes_in_use <= bytes_in_use + size_q;
        entries <= entries + 1'b1;
      end
      if (cmd.drop_evict) evictions <= sat_inc(evictions);
      if (cmd.count_hit) hits <= sat_inc(hits);
      if (cmd.count_miss) misses <= sat_inc(misses);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      ok_q <= 1'b0;
      res_q <= '0;
    end
    if (cmd.set_ok) ok_q <= 1'b1;
    if (cmd.touch) res_q <= found_handle;
    if (cmd.srch_start) begin
      found <= 1'b0;
      have_free <= 1'b0;
      sel_oh <= '0;
    end
    if (cmd.srch_cmp) begin
      if (valid[rd_addr_q] && mem_key == key_q && !found) begin
        found <= 1'b1;
        sel_idx <= rd_addr_q;
        sel_oh <= TABLE_SLOTS'(1) << rd_addr_q;
        found_kind <= mem_q[64];
        found_size <= mem_q[63:32];
        found_handle <= mem_q[31:0];
      end
      if (!valid[rd_addr_q] && !have_free) begin
        have_free <= 1'b1;
        free_idx <= rd_addr_q;
      end
    end
    if (cmd.calc_rank) rsel <= rank_or;
    if (cmd.sel_oldest) begin
      sel_idx <= old_idx;
      rsel <= last_rank;
    end
    if (cmd.drop) begin
      free_idx <= sel_idx;
      have_free <= 1'b1;
    end
    if (cmd.load_out) begin
      m_tdata <= {evictions, misses, hits, bytes_in_use, 7'(entries), res_q, ok_q};
    end
  end

endmodule

// ----- rtl/core/byte_budget_lru_cache_unit.sv -----
// Channel  Signals                       Contents
// s        s_tvalid s_tready s_tdata     request item
// m        m_tvalid m_tready m_tdata     result item
// cfg      cfg_wen cfg_wdata             max_bytes register
//
// Lookup, contains, remove and insert run a key search that reads the slot memory
// one entry per cycle; an insert then evicts the oldest entry until the new one fits.
// Clear, a rejected insert and an unused code skip the search. A new item is taken
// only in the idle state, once the previous item has passed its final step.
// rst is synchronous: the table comes up empty, counters zero, budget 64 MiB.
// A finished result waits in the output register while the next item is taken;
// a stalled result holds the block in its final step until it is taken.
module byte_budget_lru_cache_unit
  import bblc_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // req_type[2:0], key_id[66:3], item_kind[67], entry_bytes[99:68],
  // payload_handle[131:100], item_present[132], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // ok[0], result_handle[32:1], entry_count[39:33], total_bytes[71:40],
  // hit_count[103:72], miss_count[135:104], eviction_count[167:136]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wen,
  input  logic [31:0]            cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr;

  bblc_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts(sts),
    .cmd(cmd),
    .rd_addr(rd_addr)
  );

  bblc_dpath #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dpath (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .m_tdata(m_tdata),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .sts(sts)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.sel_oldest |-> sts.nonempty)
    else $error("eviction from empty table");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    cmd.write_new |-> !sts.full && !sts.over_budget)
    else $error("insert without room");

endmodule
